// ----- design/string_to_unsigned_parser_macros.svh -----
// Assertion macros used by the string-to-unsigned parser RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef STRING_TO_UNSIGNED_PARSER_MACROS_SVH
`define STRING_TO_UNSIGNED_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define STU_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, held off during reset
`define STU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STU_ASSERT(label, clk, rstn, ante, cons)
`define STU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- design/stu_pkg.sv -----
// Types, character codes and the digit decoder of the string-to-unsigned parser.
// Depends on nothing; imported by every parser module.
package stu_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int BASE_W     = 6;
    localparam logic [CFG_ADDR_W-3:0] REG_NUMBER_BASE = '0;

    // radix codes
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] NO_DIGIT  = 6'd63;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] LETTER_OFS = 8'd10;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        DS_NONE,
        DS_VALID,
        DS_OVF
    } dstat_t;

    // conversion control state
    typedef struct packed {
        phase_t              phase;
        logic                negative;
        dstat_t              dstat;
        logic [BASE_W-1:0]   base;
    } stu_ctrl_t;

    // per-step result flags
    typedef struct packed {
        logic emit;
        logic overflow;
        logic got_digits;
    } stu_res_t;

    // digit value 0..35, NO_DIGIT for anything else
    function automatic logic [BASE_W-1:0] stu_digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = {2'b00, NO_DIGIT};
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            t = c - CH_UPPER_A + LETTER_OFS;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            t = c - CH_LOWER_A + LETTER_OFS;
        end
        return t[BASE_W-1:0];
    endfunction

endpackage

// ----- design/string_to_unsigned_parser.sv -----
// Top level of the streaming string-to-unsigned parser.
// Depends on stu_pkg, stu_cfg, stu_step and string_to_unsigned_parser_macros.svh.
//
// Takes one text character per request and keeps one conversion in flight:
// leading tab/CR/space are skipped, one sign is taken, 0x/0X or a leading zero
// select the radix when number_base is 0 (or 16 for 0x), and digits accumulate
// up to the base, saturating to all ones on overflow. The first character that
// is not a digit produces one result request with the value, overflow flag,
// got_digits and the end offset (0 when no digits were seen). The block takes
// one character every cycle unless a result would land on an unread result; a
// character is registered on acceptance and then stepped, which registers any
// result. The rate is set by the conversion state recurrence: the accumulator
// multiply-add and its range check are combinational. number_base is sampled
// when a character marked first is stepped.
`include "string_to_unsigned_parser_macros.svh"

module string_to_unsigned_parser #(
    parameter int VALUE_BITS    = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // character requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_ch,
    input  logic                              s_first,
    // result requests
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [VALUE_BITS-1:0]             m_value,
    output logic                              m_overflow,
    output logic                              m_got_digits,
    output logic [POSITION_BITS-1:0]          m_end_offset,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stu_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import stu_pkg::*;

    logic [BASE_W-1:0]          number_base;

    logic                       in_valid_reg;
    logic [7:0]                 in_ch_reg;
    logic                       in_first_reg;

    stu_ctrl_t                  ctrl_reg;
    stu_ctrl_t                  ctrl_next;
    logic [VALUE_BITS-1:0]      acc_reg;
    logic [VALUE_BITS-1:0]      acc_next;
    logic [POSITION_BITS-1:0]   pos_reg;
    logic [POSITION_BITS-1:0]   pos_next;

    stu_res_t                   res;
    logic [VALUE_BITS-1:0]      res_value;
    logic [POSITION_BITS-1:0]   res_offset;

    logic                       m_valid_reg;
    logic [VALUE_BITS-1:0]      m_value_reg;
    logic                       m_overflow_reg;
    logic                       m_got_digits_reg;
    logic [POSITION_BITS-1:0]   m_end_offset_reg;

    logic                       fire;

    stu_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .number_base (number_base)
    );

    stu_step #(
        .VALUE_BITS    (VALUE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .ch          (in_ch_reg),
        .first       (in_first_reg),
        .number_base (number_base),
        .ctrl        (ctrl_reg),
        .acc         (acc_reg),
        .pos         (pos_reg),
        .ctrl_next   (ctrl_next),
        .acc_next    (acc_next),
        .pos_next    (pos_next),
        .res         (res),
        .res_value   (res_value),
        .res_offset  (res_offset)
    );

    // step proceeds unless its result would land on an unread result
    assign fire    = in_valid_reg && (!res.emit || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_ch_reg    <= s_ch;
            in_first_reg <= s_first;
        end
    end

    // conversion state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.phase    <= PH_IDLE;
            ctrl_reg.negative <= 1'b0;
            ctrl_reg.dstat    <= DS_NONE;
            ctrl_reg.base     <= BASE_DEC;
            acc_reg           <= '0;
            pos_reg           <= '0;
        end else if (fire) begin
            ctrl_reg <= ctrl_next;
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && res.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (fire && res.emit) begin
            m_value_reg      <= res_value;
            m_overflow_reg   <= res.overflow;
            m_got_digits_reg <= res.got_digits;
            m_end_offset_reg <= res_offset;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_overflow   = m_overflow_reg;
    assign m_got_digits = m_got_digits_reg;
    assign m_end_offset = m_end_offset_reg;

    // checks
    `STU_ASSERT(a_no_digits_zero, aclk, aresetn, m_valid_reg && !m_got_digits_reg, m_end_offset_reg == '0 && m_value_reg == '0 && !m_overflow_reg)
    `STU_ASSERT(a_ovf_saturates, aclk, aresetn, m_valid_reg && m_overflow_reg, (&m_value_reg) && m_got_digits_reg)
    `STU_ASSERT_NEXT(a_emit_lands, aclk, aresetn, fire && res.emit, m_valid_reg)
    `STU_ASSERT(a_idle_silent, aclk, aresetn, in_valid_reg && !in_first_reg && ctrl_reg.phase == PH_IDLE, !res.emit)

endmodule

// ----- design/stu_cfg.sv -----
// Configuration register file (number_base) behind an APB-style port.
// Depends on stu_pkg.
module stu_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stu_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [stu_pkg::BASE_W-1:0]        number_base
);
    import stu_pkg::*;

    logic [BASE_W-1:0]       base_reg;
    logic [CFG_ADDR_W-3:0]   reg_idx;
    logic                    wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_DEC;
        end else if (wr_en && reg_idx == REG_NUMBER_BASE) begin
            base_reg <= pwdata[BASE_W-1:0];
        end
    end

    // read mux
    assign prdata = (reg_idx == REG_NUMBER_BASE) ? {{(32-BASE_W){1'b0}}, base_reg} : '0;

    assign number_base = base_reg;

endmodule

// ----- design/stu_step.sv -----
// One parse step: next conversion state and the result for one character.
// Depends on stu_pkg; purely combinational.
module stu_step #(
    parameter int VALUE_BITS    = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic [7:0]                  ch,
    input  logic                        first,
    input  logic [stu_pkg::BASE_W-1:0]  number_base,
    input  stu_pkg::stu_ctrl_t          ctrl,
    input  logic [VALUE_BITS-1:0]       acc,
    input  logic [POSITION_BITS-1:0]    pos,
    output stu_pkg::stu_ctrl_t          ctrl_next,
    output logic [VALUE_BITS-1:0]       acc_next,
    output logic [POSITION_BITS-1:0]    pos_next,
    output stu_pkg::stu_res_t           res,
    output logic [VALUE_BITS-1:0]       res_value,
    output logic [POSITION_BITS-1:0]    res_offset
);
    import stu_pkg::*;

    localparam int PROD_W = VALUE_BITS + BASE_W;

    stu_ctrl_t               cur;
    logic [VALUE_BITS-1:0]   a;
    logic [POSITION_BITS-1:0] p;
    logic [POSITION_BITS-1:0] p_inc;
    logic [BASE_W-1:0]       dval;
    logic [BASE_W-1:0]       d_base;
    logic [BASE_W-1:0]       eff_base;
    logic [VALUE_BITS-1:0]   d_acc;
    dstat_t                  d_ds;
    logic                    do_digit;
    logic                    is_ws;
    logic                    is_sign;
    logic                    is_x;
    logic                    pfx_base;
    logic [PROD_W-1:0]       prod;
    logic                    prod_ovf;
    logic                    got;

    assign dval = stu_digit_of(ch);

    always_comb begin
        // a first character restarts the conversion
        cur = ctrl;
        a   = acc;
        p   = pos;
        if (first) begin
            cur.phase    = PH_LEAD;
            cur.negative = 1'b0;
            cur.dstat    = DS_NONE;
            cur.base     = number_base;
            a            = '0;
            p            = '0;
        end
        p_inc = (&p) ? p : p + 1'b1;

        is_ws    = (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_SPACE);
        is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
        is_x     = (ch == CH_UPPER_X) || (ch == CH_LOWER_X);
        pfx_base = (cur.base == BASE_AUTO) || (cur.base == BASE_HEX);

        ctrl_next = cur;
        acc_next  = a;
        pos_next  = p;
        d_base    = cur.base;
        d_acc     = a;
        d_ds      = cur.dstat;
        do_digit  = 1'b0;

        // prefix handling
        unique case (cur.phase)
            PH_IDLE: begin
            end
            PH_LEAD, PH_SIGNED: begin
                if (cur.phase == PH_LEAD && is_ws) begin
                    pos_next = p_inc;
                end else if (cur.phase == PH_LEAD && is_sign) begin
                    ctrl_next.negative = (ch == CH_MINUS);
                    ctrl_next.phase    = PH_SIGNED;
                    pos_next           = p_inc;
                end else if (ch == CH_ZERO && pfx_base) begin
                    ctrl_next.phase = PH_ZERO;
                    pos_next        = p_inc;
                end else begin
                    if (cur.base == BASE_AUTO) begin
                        d_base = BASE_DEC;
                    end
                    do_digit = 1'b1;
                end
            end
            PH_ZERO: begin
                if (is_x) begin
                    ctrl_next.base  = BASE_HEX;
                    ctrl_next.phase = PH_DIGITS;
                    pos_next        = p_inc;
                end else begin
                    // the leading zero counts as a digit
                    if (cur.base == BASE_AUTO) begin
                        d_base = BASE_OCT;
                    end
                    d_acc    = '0;
                    d_ds     = DS_VALID;
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
                ctrl_next.phase = PH_IDLE;
            end
        endcase

        // multiply-add with range check
        eff_base = (d_base == BASE_AUTO) ? BASE_DEC : d_base;
        prod     = PROD_W'(d_acc) * PROD_W'(eff_base) + PROD_W'(dval);
        prod_ovf = |prod[PROD_W-1:VALUE_BITS];

        res        = '0;
        got        = (d_ds != DS_NONE);
        res_value  = '0;
        res_offset = '0;

        if (do_digit) begin
            ctrl_next.base  = d_base;
            ctrl_next.phase = PH_DIGITS;
            ctrl_next.dstat = d_ds;
            acc_next        = d_acc;
            if (dval < eff_base) begin
                if (d_ds == DS_OVF || prod_ovf) begin
                    ctrl_next.dstat = DS_OVF;
                end else begin
                    ctrl_next.dstat = DS_VALID;
                    acc_next        = prod[VALUE_BITS-1:0];
                end
                pos_next = p_inc;
            end else begin
                // terminator: report and go idle
                ctrl_next.phase = PH_IDLE;
                res.emit        = 1'b1;
                res.overflow    = (d_ds == DS_OVF);
                res.got_digits  = got;
                if (d_ds == DS_OVF) begin
                    res_value = '1;
                end else if (cur.negative) begin
                    res_value = '0 - d_acc;
                end else begin
                    res_value = d_acc;
                end
                res_offset = got ? p : '0;
            end
        end
    end

endmodule
